// ----- rtl/csdm_pkg.sv -----
`default_nettype none
package csdm_pkg;

    typedef enum logic [1:0] {
        MODE_PTR   = 2'd0,
        MODE_NZ    = 2'd1,
        MODE_DENSE = 2'd2,
        MODE_READ  = 2'd3
    } mode_t;

    typedef enum logic [1:0] {
        CFG_ROWS  = 2'd0,
        CFG_COLS  = 2'd1,
        CFG_LANES = 2'd2
    } cfg_idx_t;

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_PTR_RD,
        ST_PTR_WAIT,
        ST_WALK,
        ST_ACC_RD,
        ST_ACC_WR,
        ST_RD_WAIT,
        ST_RD_DONE,
        ST_CLEAR
    } state_t;

    localparam int ACC_W = 48;

    typedef struct packed {
        logic [1:0]         mode;
        logic [8:0]         column;
        logic [12:0]        pointer;
        logic [11:0]        position;
        logic [7:0]         row;
        logic [3:0]         lane;
        logic signed [15:0] value;
    } in_item_t;

    typedef struct packed {
        logic signed [31:0] result_value;
        logic [7:0]         result_row;
        logic [3:0]         result_lane;
    } out_item_t;

    typedef struct packed {
        logic load_item;
        logic clear_step;
        logic clear_start;
        logic ptr_read;
        logic ptr_capture;
        logic nz_read;
        logic acc_read;
        logic acc_write;
        logic rd_read;
        logic rd_emit;
        logic slot_step;
    } cmd_t;

    typedef struct packed {
        logic ptr_write;
        logic nz_write;
        logic is_dense;
        logic is_read;
        logic walk_done;
        logic row_ok;
        logic clear_done;
        logic out_busy;
    } status_t;

endpackage
`default_nettype wire

// ----- rtl/csdm_ram.sv -----
`default_nettype none
module csdm_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  wire logic                     aclk,
    input  wire logic                     we,
    input  wire logic [$clog2(DEPTH)-1:0] waddr,
    input  wire logic [WIDTH-1:0]         wdata,
    input  wire logic [$clog2(DEPTH)-1:0] raddr,
    output logic      [WIDTH-1:0]         rdata
);
    logic [WIDTH-1:0] mem [DEPTH];
    always_ff @(posedge aclk) begin
        if (we) begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end
endmodule
`default_nettype wire

// ----- rtl/csdm_ctrl.sv -----
`default_nettype none
module csdm_ctrl (
    input  wire logic              aclk,
    input  wire logic              aresetn,
    input  wire logic              s_valid,
    output logic                   s_ready,
    input  wire csdm_pkg::status_t sts,
    output csdm_pkg::cmd_t         cmd
);
    import csdm_pkg::*;

    state_t state_reg, state_next;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= ST_CLEAR;
        end else begin
            state_reg <= state_next;
        end
    end

    always_comb begin
        state_next = state_reg;
        cmd        = '0;
        s_ready    = 1'b0;
        unique case (state_reg)
            ST_CLEAR: begin
                cmd.clear_step = 1'b1;
                if (sts.clear_done) begin
                    state_next = ST_IDLE;
                end
            end
            ST_IDLE: begin
                s_ready = 1'b1;
                if (s_valid) begin
                    cmd.load_item = 1'b1;
                    if (sts.is_dense) begin
                        state_next = ST_PTR_RD;
                    end else if (sts.is_read) begin
                        state_next = ST_RD_WAIT;
                    end
                end
            end
            ST_PTR_RD: begin
                cmd.ptr_read = 1'b1;
                state_next   = ST_PTR_WAIT;
            end
            ST_PTR_WAIT: begin
                cmd.ptr_capture = 1'b1;
                state_next      = ST_WALK;
            end
            ST_WALK: begin
                if (sts.walk_done) begin
                    state_next = ST_IDLE;
                end else begin
                    cmd.nz_read = 1'b1;
                    state_next  = ST_ACC_RD;
                end
            end
            ST_ACC_RD: begin
                cmd.acc_read = 1'b1;
                state_next   = ST_ACC_WR;
            end
            ST_ACC_WR: begin
                cmd.acc_write = sts.row_ok;
                cmd.slot_step = 1'b1;
                state_next    = ST_WALK;
            end
            ST_RD_WAIT: begin
                cmd.rd_read = 1'b1;
                state_next  = ST_RD_DONE;
            end
            ST_RD_DONE: begin
                if (!sts.out_busy) begin
                    cmd.rd_emit = 1'b1;
                    state_next  = ST_IDLE;
                end
            end
            default: state_next = ST_IDLE;
        endcase
    end
endmodule
`default_nettype wire

// ----- rtl/csdm_datapath.sv -----
`default_nettype none
module csdm_datapath #(
    parameter int MAX_ROWS     = 256,
    parameter int MAX_COLS     = 256,
    parameter int MAX_NONZEROS = 4096,
    parameter int MAX_LANES    = 16
) (
    input  wire logic                aclk,
    input  wire logic                aresetn,
    input  wire csdm_pkg::cmd_t      cmd,
    output csdm_pkg::status_t        sts,
    input  wire csdm_pkg::in_item_t  s_item,
    input  wire logic                s_accept,
    input  wire logic [8:0]          rows_eff,
    input  wire logic [8:0]          cols_eff,
    input  wire logic [4:0]          lanes_eff,
    output csdm_pkg::out_item_t      m_item,
    output logic                     m_valid,
    input  wire logic                m_ready
);
    import csdm_pkg::*;

    localparam int CP_D   = MAX_COLS + 1;
    localparam int CP_AW  = $clog2(CP_D);
    localparam int NZ_AW  = (MAX_NONZEROS > 1) ? $clog2(MAX_NONZEROS) : 1;
    localparam int NZ_D   = 1 << NZ_AW;
    localparam int LN_W   = (MAX_LANES > 1) ? $clog2(MAX_LANES) : 1;
    localparam int RW_W   = (MAX_ROWS > 1) ? $clog2(MAX_ROWS) : 1;
    localparam int AC_AW  = RW_W + LN_W;
    localparam int AC_D   = 1 << AC_AW;
    localparam int SL_W   = NZ_AW + 1;
    localparam logic [SL_W-1:0] NZ_MAX = SL_W'(MAX_NONZEROS);
    localparam logic signed [ACC_W-1:0] ACC_HI = {1'b0, {(ACC_W-1){1'b1}}};
    localparam logic signed [ACC_W-1:0] ACC_LO = {1'b1, {(ACC_W-1){1'b0}}};

    in_item_t item_reg;
    logic [SL_W-1:0] slot_reg, end_reg;
    logic [AC_AW:0] clr_reg;
    logic [12:0] cp_rdata;
    logic [7:0] nzr_rdata;
    logic [15:0] nzv_rdata;
    logic [ACC_W-1:0] acc_rdata;
    logic signed [31:0] prod_reg;
    logic [7:0] nzrow_reg;
    logic [AC_AW-1:0] acc_waddr, acc_raddr;
    logic [ACC_W-1:0] acc_wdata;
    logic acc_we;
    logic [CP_AW-1:0] cp_raddr;
    logic [12:0] lo_ptr;
    logic signed [ACC_W:0] sum;
    logic signed [ACC_W-1:0] sat_sum, acc_s;
    logic signed [ACC_W-16:0] shifted;
    logic signed [31:0] scaled;
    logic rd_ok;
    logic cp_hit, cp_we, nz_we;
    logic [12:0] start_c;

    assign cp_hit = {4'd0, s_item.column} <= 13'(MAX_COLS);
    assign cp_we  = s_accept && s_item.mode == MODE_PTR && cp_hit;
    assign nz_we  = s_accept && s_item.mode == MODE_NZ
                    && {1'b0, s_item.position} < 13'(MAX_NONZEROS);

    assign sts.ptr_write  = cp_we;
    assign sts.nz_write   = nz_we;
    assign sts.is_dense   = s_item.mode == MODE_DENSE
                            && s_item.column < cols_eff
                            && {1'b0, s_item.lane} < lanes_eff;
    assign sts.is_read    = s_item.mode == MODE_READ;
    assign sts.walk_done  = slot_reg >= end_reg;
    assign sts.row_ok     = {1'b0, nzrow_reg} < rows_eff;
    assign sts.clear_done = clr_reg == (AC_AW+1)'(AC_D - 1);
    assign sts.out_busy   = m_valid && !m_ready;

    always_ff @(posedge aclk) begin
        if (cmd.load_item) begin
            item_reg <= s_item;
        end
    end

    // column start pointers: read start, then end
    always_comb begin
        if (cmd.load_item) begin
            cp_raddr = CP_AW'(s_item.column);
        end else begin
            cp_raddr = CP_AW'(item_reg.column + 9'd1);
        end
    end

    csdm_ram #(.WIDTH(13), .DEPTH(CP_D)) u_cp (
        .aclk(aclk), .we(cp_we), .waddr(CP_AW'(s_item.column)),
        .wdata(s_item.pointer), .raddr(cp_raddr), .rdata(cp_rdata)
    );

    // start arrives in cycle after load and is held in lo_ptr; end is read from column + 1 after it
    always_ff @(posedge aclk) begin
        if (cmd.ptr_read) begin
            lo_ptr <= cp_rdata;
        end
    end

    assign start_c = lo_ptr;

    always_ff @(posedge aclk) begin
        if (cmd.ptr_capture) begin
            slot_reg <= (SL_W'(start_c) > NZ_MAX || start_c > 13'(MAX_NONZEROS))
                        ? NZ_MAX : SL_W'(start_c);
            end_reg  <= (SL_W'(cp_rdata) > NZ_MAX || cp_rdata > 13'(MAX_NONZEROS))
                        ? NZ_MAX : SL_W'(cp_rdata);
        end else if (cmd.slot_step) begin
            slot_reg <= slot_reg + 1'b1;
        end
    end

    csdm_ram #(.WIDTH(8), .DEPTH(NZ_D)) u_nzr (
        .aclk(aclk), .we(nz_we), .waddr(NZ_AW'(s_item.position)),
        .wdata(s_item.row), .raddr(slot_reg[NZ_AW-1:0]), .rdata(nzr_rdata)
    );

    csdm_ram #(.WIDTH(16), .DEPTH(NZ_D)) u_nzv (
        .aclk(aclk), .we(nz_we), .waddr(NZ_AW'(s_item.position)),
        .wdata(s_item.value), .raddr(slot_reg[NZ_AW-1:0]), .rdata(nzv_rdata)
    );

    always_ff @(posedge aclk) begin
        if (cmd.acc_read) begin
            prod_reg  <= $signed(nzv_rdata) * item_reg.value;
            nzrow_reg <= nzr_rdata;
        end
    end

    always_comb begin
        if (cmd.acc_read) begin
            acc_raddr = {RW_W'(nzr_rdata), LN_W'(item_reg.lane)};
        end else begin
            acc_raddr = {RW_W'(item_reg.row), LN_W'(item_reg.lane)};
        end
    end

    assign acc_s = $signed(acc_rdata);
    assign sum   = {acc_s[ACC_W-1], acc_s} + (ACC_W+1)'(prod_reg);
    always_comb begin
        if (sum > $signed({ACC_HI[ACC_W-1], ACC_HI})) begin
            sat_sum = ACC_HI;
        end else if (sum < $signed({ACC_LO[ACC_W-1], ACC_LO})) begin
            sat_sum = ACC_LO;
        end else begin
            sat_sum = sum[ACC_W-1:0];
        end
    end

    assign rd_ok = {1'b0, item_reg.row} < rows_eff && {1'b0, item_reg.lane} < lanes_eff;

    always_comb begin
        acc_we    = 1'b0;
        acc_waddr = {RW_W'(nzrow_reg), LN_W'(item_reg.lane)};
        acc_wdata = sat_sum;
        if (cmd.clear_step) begin
            acc_we    = 1'b1;
            acc_waddr = clr_reg[AC_AW-1:0];
            acc_wdata = '0;
        end else if (cmd.acc_write) begin
            acc_we = 1'b1;
        end else if (cmd.rd_emit && rd_ok) begin
            acc_we    = 1'b1;
            acc_waddr = {RW_W'(item_reg.row), LN_W'(item_reg.lane)};
            acc_wdata = '0;
        end
    end

    csdm_ram #(.WIDTH(ACC_W), .DEPTH(AC_D)) u_acc (
        .aclk(aclk), .we(acc_we), .waddr(acc_waddr),
        .wdata(acc_wdata), .raddr(acc_raddr), .rdata(acc_rdata)
    );

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            clr_reg <= '0;
        end else if (cmd.clear_step && !sts.clear_done) begin
            clr_reg <= clr_reg + 1'b1;
        end
    end

    assign shifted = acc_s[ACC_W-1:15];
    always_comb begin
        if (shifted > $signed(33'sh07FFFFFFF)) begin
            scaled = 32'sh7FFFFFFF;
        end else if (shifted < -$signed(33'sh080000000)) begin
            scaled = 32'sh80000000;
        end else begin
            scaled = shifted[31:0];
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid <= 1'b0;
        end else if (cmd.rd_emit) begin
            m_valid <= 1'b1;
        end else if (m_ready) begin
            m_valid <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (cmd.rd_emit) begin
            m_item.result_value <= rd_ok ? scaled : '0;
            m_item.result_row   <= item_reg.row;
            m_item.result_lane  <= item_reg.lane;
        end
    end
endmodule
`default_nettype wire

// ----- rtl/csc_sparse_dense_matmul_top.sv -----
`default_nettype none
// channel   ports                         role
// s_        s_valid s_ready s_item        input item (mode, column, ...)
// m_        m_valid m_ready m_item        result item for reads
// cfg_      cfg_valid cfg_ready cfg_index cfg_data   register write
// a pointer or nonzero load is written in IDLE, which it does not leave;
// a read passes RD_WAIT and RD_DONE; a dense element in range passes PTR_RD and
// PTR_WAIT, then WALK, ACC_RD, ACC_WR per nonzero (serial read-modify-write)
// after reset all 2**(log2 rows + log2 lanes) accumulator entries (4096 by
// default) are cleared while s_ready stays low
// a read waits while the output register still holds an untaken item
module csc_sparse_dense_matmul_top #(
    parameter int MAX_ROWS     = 256,
    parameter int MAX_COLS     = 256,
    parameter int MAX_NONZEROS = 4096,
    parameter int MAX_LANES    = 16
) (
    input  wire logic                aclk,
    input  wire logic                aresetn,
    input  wire logic                s_valid,
    output logic                     s_ready,
    input  wire csdm_pkg::in_item_t  s_item,
    output logic                     m_valid,
    input  wire logic                m_ready,
    output csdm_pkg::out_item_t      m_item,
    input  wire logic                cfg_valid,
    output logic                     cfg_ready,
    input  wire logic [1:0]          cfg_index,
    input  wire logic [8:0]          cfg_data
);
    import csdm_pkg::*;

    logic [8:0] row_count_reg, col_count_reg;
    logic [4:0] lane_count_reg;
    logic [8:0] rows_eff, cols_eff;
    logic [4:0] lanes_eff;
    cmd_t cmd;
    status_t sts;

    assign cfg_ready = 1'b1;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            row_count_reg  <= 9'd256;
            col_count_reg  <= 9'd256;
            lane_count_reg <= 5'd16;
        end else if (cfg_valid) begin
            unique case (cfg_index)
                CFG_ROWS:  row_count_reg  <= cfg_data;
                CFG_COLS:  col_count_reg  <= cfg_data;
                CFG_LANES: lane_count_reg <= cfg_data[4:0];
                default: ;
            endcase
        end
    end

    assign rows_eff  = (32'(row_count_reg) > MAX_ROWS) ? 9'(MAX_ROWS) : row_count_reg;
    assign cols_eff  = (32'(col_count_reg) > MAX_COLS) ? 9'(MAX_COLS) : col_count_reg;
    assign lanes_eff = (32'(lane_count_reg) > MAX_LANES) ? 5'(MAX_LANES) : lane_count_reg;

    csdm_ctrl u_ctrl (
        .aclk(aclk), .aresetn(aresetn), .s_valid(s_valid), .s_ready(s_ready),
        .sts(sts), .cmd(cmd)
    );

    csdm_datapath #(
        .MAX_ROWS(MAX_ROWS), .MAX_COLS(MAX_COLS),
        .MAX_NONZEROS(MAX_NONZEROS), .MAX_LANES(MAX_LANES)
    ) u_dp (
        .aclk(aclk), .aresetn(aresetn), .cmd(cmd), .sts(sts),
        .s_item(s_item), .s_accept(s_valid && s_ready),
        .rows_eff(rows_eff), .cols_eff(cols_eff), .lanes_eff(lanes_eff),
        .m_item(m_item), .m_valid(m_valid), .m_ready(m_ready)
    );
endmodule
`default_nettype wire
